[hw/rtl/rqe_pkg.sv]
package rqe_pkg;

    localparam int IN_W   = 16;
    localparam int PRD_W  = 32;
    localparam int P_W    = 34;
    localparam int PK_W   = 32;
    localparam int SQ_W   = 64;
    localparam int V_W    = 66;
    localparam int SC_W   = 31;
    localparam int X_W    = 34;
    localparam int Z_W    = 35;
    localparam int OUT_W  = 16;
    localparam int HP_W   = 63;
    localparam int MAX_STEPS = 24;

    localparam logic signed [Z_W-1:0] ANG_PI = 35'sd3373259426;
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic signed [OUT_W-1:0] OUT_PI = 16'sd25736;
    localparam logic signed [OUT_W-1:0] OUT_HALF_PI = 16'sd12868;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cordic_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] a;
        unique case (i)
            0:  a = 32'd843314857;
            1:  a = 32'd497837829;
            2:  a = 32'd263043837;
            3:  a = 32'd133525159;
            4:  a = 32'd67021687;
            5:  a = 32'd33543516;
            6:  a = 32'd16775851;
            7:  a = 32'd8388437;
            8:  a = 32'd4194283;
            9:  a = 32'd2097149;
            10: a = 32'd1048576;
            11: a = 32'd524288;
            12: a = 32'd262144;
            13: a = 32'd131072;
            14: a = 32'd65536;
            15: a = 32'd32768;
            16: a = 32'd16384;
            17: a = 32'd8192;
            18: a = 32'd4096;
            19: a = 32'd2048;
            20: a = 32'd1024;
            21: a = 32'd512;
            22: a = 32'd256;
            23: a = 32'd128;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Q2.30 angle to Q2.13 with rounding, clamped to +/- lim.
    function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [Z_W-1:0] z,
                                                        input logic signed [OUT_W-1:0] lim);
        logic signed [Z_W-1:0] r;
        logic signed [Z_W-1:0] l;
        logic signed [OUT_W-1:0] q;
        r = (z + Z_W'(65536)) >>> 17;
        l = Z_W'(lim);
        if (r > l) begin
            q = lim;
        end else if (r < -l) begin
            q = -lim;
        end else begin
            q = OUT_W'(r);
        end
        return q;
    endfunction

endpackage

[hw/rtl/rqe_cordic_cell.sv]
module rqe_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  rqe_pkg::cordic_t d_in,
    output rqe_pkg::cordic_t d_out
);

    localparam logic signed [rqe_pkg::Z_W-1:0] ANGLE =
        rqe_pkg::Z_W'(rqe_pkg::atan_q30(STEP));

    rqe_pkg::cordic_t d_reg;
    rqe_pkg::cordic_t d_next;
    logic signed [rqe_pkg::X_W-1:0] xs;
    logic signed [rqe_pkg::X_W-1:0] ys;

    always_comb begin
        xs = d_in.x >>> STEP;
        ys = d_in.y >>> STEP;
        if (d_in.y < 0) begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - ANGLE;
        end else begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

[hw/rtl/rqe_cordic_chain.sv]
module rqe_cordic_chain #(
    parameter int NSTEPS = 16,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  rqe_pkg::cordic_t  d_in,
    input  logic [SIDE_W-1:0] side_in,
    output rqe_pkg::cordic_t  d_out,
    output logic [SIDE_W-1:0] side_out
);

    rqe_pkg::cordic_t link [NSTEPS+1];
    logic [SIDE_W-1:0] side_reg [NSTEPS];

    assign link[0] = d_in;

    for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
        rqe_cordic_cell #(.STEP(i)) u_cell (
            .aclk (aclk),
            .en   (en),
            .d_in (link[i]),
            .d_out(link[i+1])
        );

        // Side data rides along with the cell that holds its vector.
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= (i == 0) ? side_in : side_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign d_out    = link[NSTEPS];
    assign side_out = side_reg[NSTEPS-1];

endmodule

[hw/rtl/relative_quaternion_to_euler.sv]
// Channel | Dir | tdata fields (low bit up)                    | tuser
// s_      | in  | ref_w ref_x ref_y ref_z tgt_w tgt_x tgt_y tgt_z | -
// m_      | out | roll[15:0] pitch[30:16] yaw[46:31] pad         | degenerate
//
// One transaction per cycle is taken while no result waits on a low m_tready. Each CORDIC
// cell chain has CORDIC_STEPS cells, capped at 24; the yaw and pitch chains run in series.
// Reset clears only the stage valid bits.
// When a result waits and m_tready is low, every stage holds and s_tready drops.
module relative_quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // ref_w, ref_x, ref_y, ref_z, tgt_w, tgt_x, tgt_y, tgt_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // roll, pitch, yaw, one zero pad bit
    output logic         m_tuser    // degenerate
);

    localparam int NSTEPS = (CORDIC_STEPS < rqe_pkg::MAX_STEPS) ?
                            CORDIC_STEPS : rqe_pkg::MAX_STEPS;
    localparam int LAT = 13 + 2 * NSTEPS;
    localparam int SIDE1_W = 2 + rqe_pkg::SC_W;
    localparam int SIDE2_W = 2 + 2 * rqe_pkg::OUT_W;

    logic [LAT-1:0] valid_reg;
    logic en;

    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    function automatic logic [6:0] lead_pos(input logic [rqe_pkg::V_W-1:0] m);
        logic [6:0] pos;
        pos = '0;
        for (int i = 0; i < rqe_pkg::V_W; i++) begin
            if (m[i]) begin
                pos = 7'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [rqe_pkg::V_W-1:0] vmag(input logic signed [rqe_pkg::V_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Folds a vector with negative x into the right half plane.
    function automatic rqe_pkg::cordic_t pre_rot(input logic signed [rqe_pkg::X_W-1:0] y,
                                                 input logic signed [rqe_pkg::X_W-1:0] x);
        rqe_pkg::cordic_t c;
        if (x < 0) begin
            c.x = -x;
            c.y = -y;
            c.z = (y >= 0) ? rqe_pkg::ANG_PI : -rqe_pkg::ANG_PI;
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        return c;
    endfunction

    // Stage 1: input registers.
    logic signed [rqe_pkg::IN_W-1:0] r_reg [4];
    logic signed [rqe_pkg::IN_W-1:0] t_reg [4];
    logic degen1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_reg[i] <= s_tdata[16*i +: 16];
                t_reg[i] <= s_tdata[64 + 16*i +: 16];
            end
            degen1_reg <= (s_tdata[63:0] == '0) || (s_tdata[127:64] == '0);
        end
    end

    // Stage 2: all sixteen component products.
    logic signed [rqe_pkg::PRD_W-1:0] pr_reg [4][4];
    logic degen2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    pr_reg[i][j] <= r_reg[i] * t_reg[j];
                end
            end
            degen2_reg <= degen1_reg;
        end
    end

    // Stage 3: conj(ref) * tgt.
    logic signed [rqe_pkg::P_W-1:0] p_reg [4];
    logic degen3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= rqe_pkg::P_W'(pr_reg[0][0]) + rqe_pkg::P_W'(pr_reg[1][1])
                      + rqe_pkg::P_W'(pr_reg[2][2]) + rqe_pkg::P_W'(pr_reg[3][3]);
            p_reg[1] <= rqe_pkg::P_W'(pr_reg[0][1]) - rqe_pkg::P_W'(pr_reg[1][0])
                      - rqe_pkg::P_W'(pr_reg[2][3]) + rqe_pkg::P_W'(pr_reg[3][2]);
            p_reg[2] <= rqe_pkg::P_W'(pr_reg[0][2]) + rqe_pkg::P_W'(pr_reg[1][3])
                      - rqe_pkg::P_W'(pr_reg[2][0]) - rqe_pkg::P_W'(pr_reg[3][1]);
            p_reg[3] <= rqe_pkg::P_W'(pr_reg[0][3]) - rqe_pkg::P_W'(pr_reg[1][2])
                      + rqe_pkg::P_W'(pr_reg[2][1]) - rqe_pkg::P_W'(pr_reg[3][0]);
            degen3_reg <= degen2_reg;
        end
    end

    // Stage 4: bring the product below 2^30 by a shift of at most two.
    logic [rqe_pkg::P_W-1:0] p_or;
    logic [1:0] k_shift;
    logic signed [rqe_pkg::PK_W-1:0] pk_reg [4];
    logic degen4_reg;

    always_comb begin
        p_or = '0;
        for (int i = 0; i < 4; i++) begin
            p_or = p_or | ((p_reg[i] < 0) ? -p_reg[i] : p_reg[i]);
        end
        if (p_or[rqe_pkg::P_W-1:30] == '0) begin
            k_shift = 2'd0;
        end else if (p_or[rqe_pkg::P_W-1:31] == '0) begin
            k_shift = 2'd1;
        end else begin
            k_shift = 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                pk_reg[i] <= rqe_pkg::PK_W'(p_reg[i] >>> k_shift);
            end
            degen4_reg <= degen3_reg;
        end
    end

    // Stage 5: squares and cross products.
    logic signed [rqe_pkg::SQ_W-1:0] sq_reg [4];
    logic signed [rqe_pkg::SQ_W-1:0] p01_reg, p23_reg, p03_reg, p12_reg, p02_reg, p31_reg;
    logic degen5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= pk_reg[i] * pk_reg[i];
            end
            p01_reg <= pk_reg[0] * pk_reg[1];
            p23_reg <= pk_reg[2] * pk_reg[3];
            p03_reg <= pk_reg[0] * pk_reg[3];
            p12_reg <= pk_reg[1] * pk_reg[2];
            p02_reg <= pk_reg[0] * pk_reg[2];
            p31_reg <= pk_reg[3] * pk_reg[1];
            degen5_reg <= degen4_reg;
        end
    end

    // Stage 6: atan2 operands with the norm standing in for one.
    logic signed [rqe_pkg::V_W-1:0] n_val;
    logic signed [rqe_pkg::V_W-1:0] rv0_reg, rv1_reg, yv0_reg, yv1_reg, yv2_reg;
    logic degen6_reg;

    assign n_val = rqe_pkg::V_W'(sq_reg[0]) + rqe_pkg::V_W'(sq_reg[1])
                 + rqe_pkg::V_W'(sq_reg[2]) + rqe_pkg::V_W'(sq_reg[3]);

    always_ff @(posedge aclk) begin
        if (en) begin
            rv0_reg <= (rqe_pkg::V_W'(p01_reg) + rqe_pkg::V_W'(p23_reg)) <<< 1;
            rv1_reg <= n_val - ((rqe_pkg::V_W'(sq_reg[1]) + rqe_pkg::V_W'(sq_reg[2])) <<< 1);
            yv0_reg <= (rqe_pkg::V_W'(p03_reg) + rqe_pkg::V_W'(p12_reg)) <<< 1;
            yv1_reg <= n_val - ((rqe_pkg::V_W'(sq_reg[2]) + rqe_pkg::V_W'(sq_reg[3])) <<< 1);
            yv2_reg <= (rqe_pkg::V_W'(p02_reg) - rqe_pkg::V_W'(p31_reg)) <<< 1;
            degen6_reg <= degen5_reg;
        end
    end

    // Stages 7 to 9: block scaling. The OR of magnitudes has the same leading
    // bit as their maximum.
    logic signed [rqe_pkg::V_W-1:0] v7_reg [5];
    logic [rqe_pkg::V_W-1:0] rm_reg, ym_reg;
    logic degen7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            v7_reg[0] <= rv0_reg;
            v7_reg[1] <= rv1_reg;
            v7_reg[2] <= yv0_reg;
            v7_reg[3] <= yv1_reg;
            v7_reg[4] <= yv2_reg;
            rm_reg <= vmag(rv0_reg) | vmag(rv1_reg);
            ym_reg <= vmag(yv0_reg) | vmag(yv1_reg) | vmag(yv2_reg);
            degen7_reg <= degen6_reg;
        end
    end

    logic signed [rqe_pkg::V_W-1:0] v8_reg [5];
    logic [6:0] r_rs_reg, y_rs_reg;
    logic [4:0] r_ls_reg, y_ls_reg;
    logic [6:0] r_lead, y_lead;
    logic degen8_reg;

    assign r_lead = lead_pos(rm_reg);
    assign y_lead = lead_pos(ym_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            v8_reg <= v7_reg;
            r_rs_reg <= (r_lead > 7'd28) ? r_lead - 7'd28 : 7'd0;
            r_ls_reg <= (r_lead > 7'd28) ? 5'd0 : 5'(7'd28 - r_lead);
            y_rs_reg <= (y_lead > 7'd28) ? y_lead - 7'd28 : 7'd0;
            y_ls_reg <= (y_lead > 7'd28) ? 5'd0 : 5'(7'd28 - y_lead);
            degen8_reg <= degen7_reg;
        end
    end

    logic signed [rqe_pkg::SC_W-1:0] sc_reg [5];
    logic degen9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 2; i++) begin
                sc_reg[i] <= rqe_pkg::SC_W'((v8_reg[i] <<< r_ls_reg) >>> r_rs_reg);
            end
            for (int i = 2; i < 5; i++) begin
                sc_reg[i] <= rqe_pkg::SC_W'((v8_reg[i] <<< y_ls_reg) >>> y_rs_reg);
            end
            degen9_reg <= degen8_reg;
        end
    end

    // Stage 10: CORDIC prerotation for roll and yaw.
    rqe_pkg::cordic_t roll_pre_reg, yaw_pre_reg;
    logic [SIDE1_W-1:0] side1_reg;
    logic yaw_zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_pre_reg <= pre_rot(rqe_pkg::X_W'(sc_reg[0]), rqe_pkg::X_W'(sc_reg[1]));
            yaw_pre_reg  <= pre_rot(rqe_pkg::X_W'(sc_reg[2]), rqe_pkg::X_W'(sc_reg[3]));
            side1_reg <= {degen9_reg,
                          (sc_reg[0] == '0) && (sc_reg[1] == '0),
                          sc_reg[4]};
            yaw_zero_reg <= (sc_reg[2] == '0) && (sc_reg[3] == '0);
        end
    end

    rqe_pkg::cordic_t roll_out, yaw_out;
    logic [SIDE1_W-1:0] side1_out;
    logic yaw_zero_out;

    rqe_cordic_chain #(.NSTEPS(NSTEPS), .SIDE_W(SIDE1_W)) u_roll_chain (
        .aclk    (aclk),
        .en      (en),
        .d_in    (roll_pre_reg),
        .side_in (side1_reg),
        .d_out   (roll_out),
        .side_out(side1_out)
    );

    rqe_cordic_chain #(.NSTEPS(NSTEPS), .SIDE_W(1)) u_yaw_chain (
        .aclk    (aclk),
        .en      (en),
        .d_in    (yaw_pre_reg),
        .side_in (yaw_zero_reg),
        .d_out   (yaw_out),
        .side_out(yaw_zero_out)
    );

    // Gain correction of the yaw magnitude gives the hypot for pitch.
    logic [rqe_pkg::HP_W-1:0] hprod_reg;
    logic signed [rqe_pkg::OUT_W-1:0] roll_q_reg, yaw_q_reg;
    logic signed [rqe_pkg::SC_W-1:0] yv2h_reg;
    logic degenh_reg;
    logic [32:0] hx_pos;

    assign hx_pos = (yaw_out.x < 0) ? 33'd0 : yaw_out.x[32:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            hprod_reg  <= rqe_pkg::HP_W'(hx_pos * rqe_pkg::INV_GAIN);
            roll_q_reg <= side1_out[SIDE1_W-2] ? '0 : rqe_pkg::to_q13(roll_out.z, rqe_pkg::OUT_PI);
            yaw_q_reg  <= yaw_zero_out ? '0 : rqe_pkg::to_q13(yaw_out.z, rqe_pkg::OUT_PI);
            yv2h_reg   <= side1_out[rqe_pkg::SC_W-1:0];
            degenh_reg <= side1_out[SIDE1_W-1];
        end
    end

    logic [63:0] hsum;
    logic [32:0] hc;
    rqe_pkg::cordic_t pitch_pre_reg;
    logic [SIDE2_W-1:0] side2_reg;

    assign hsum = {1'b0, hprod_reg} + 64'd536870912;
    assign hc   = hsum[62:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            pitch_pre_reg <= pre_rot(rqe_pkg::X_W'(yv2h_reg), rqe_pkg::X_W'({1'b0, hc}));
            side2_reg <= {degenh_reg, (hc == '0) && (yv2h_reg == '0), roll_q_reg, yaw_q_reg};
        end
    end

    rqe_pkg::cordic_t pitch_out;
    logic [SIDE2_W-1:0] side2_out;

    rqe_cordic_chain #(.NSTEPS(NSTEPS), .SIDE_W(SIDE2_W)) u_pitch_chain (
        .aclk    (aclk),
        .en      (en),
        .d_in    (pitch_pre_reg),
        .side_in (side2_reg),
        .d_out   (pitch_out),
        .side_out(side2_out)
    );

    // Output register.
    logic [47:0] tdata_reg;
    logic tuser_reg;
    logic signed [rqe_pkg::OUT_W-1:0] pitch_q;
    logic out_degen;

    assign out_degen = side2_out[SIDE2_W-1];
    assign pitch_q = side2_out[SIDE2_W-2] ? '0 :
                     rqe_pkg::to_q13(pitch_out.z, rqe_pkg::OUT_HALF_PI);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (out_degen) begin
                tdata_reg <= '0;
            end else begin
                tdata_reg <= {1'b0, side2_out[rqe_pkg::OUT_W-1:0], pitch_q[14:0],
                              side2_out[2*rqe_pkg::OUT_W-1:rqe_pkg::OUT_W]};
            end
            tuser_reg <= out_degen;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result carries nonzero angles");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[30:16]) <= 15'sd12868) &&
                      ($signed(m_tdata[30:16]) >= -15'sd12868)))
        else $error("pitch outside half pi");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transaction missing from pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
